FILE: rtl/stp_pkg.sv
// Shared types, mode codes and helpers of the spanning tree BPDU engine.
`default_nettype none
package stp_pkg;

	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_CONFIG = 2'd1;
	localparam logic [1:0] MODE_HELLO  = 2'd2;

	localparam logic [1:0] REG_BRIDGE_ID  = 2'd0;
	localparam logic [1:0] REG_PORT_PRIO  = 2'd1;
	localparam logic [1:0] REG_PORT_COUNT = 2'd2;
	localparam logic [1:0] REG_LINK_COST  = 2'd3;

	localparam logic [15:0] IDENT_CAP = 16'h7FFF;
	localparam int HW_PORT_LIMIT = 8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  rx_port;
		logic [63:0] root_id;
		logic [31:0] cost;
		logic [63:0] sender_id;
		logic [15:0] port_id;
	} stp_cmd_t;

	typedef struct packed {
		logic     valid;
		stp_cmd_t cmd;
	} stp_q_t;

	function automatic logic [15:0] own_ident(input logic [7:0] prio, input logic [3:0] idx);
		logic [7:0] low;
		low = 8'({4'd0, idx} + 8'd1);
		return {prio, low};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/stp_ifs.sv
// Handshake channel interfaces for BPDU input words, result words and register writes.
`default_nettype none
interface stp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [2:0]  rx_port;
	logic [63:0] bpdu_root_id;
	logic [31:0] bpdu_cost;
	logic [63:0] bpdu_switch_id;
	logic [15:0] bpdu_port_id;
	modport source (output valid, mode, rx_port, bpdu_root_id, bpdu_cost, bpdu_switch_id,
		bpdu_port_id, input ready);
	modport sink (input valid, mode, rx_port, bpdu_root_id, bpdu_cost, bpdu_switch_id,
		bpdu_port_id, output ready);
endinterface

interface stp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  tx_port;
	logic [63:0] tx_root_id;
	logic [31:0] tx_cost;
	logic [15:0] tx_port_id;
	logic        is_root;
	logic        root_port_valid;
	logic [2:0]  root_port_index;
	logic        last;
	modport source (output valid, tx_port, tx_root_id, tx_cost, tx_port_id, is_root,
		root_port_valid, root_port_index, last, input ready);
	modport sink (input valid, tx_port, tx_root_id, tx_cost, tx_port_id, is_root,
		root_port_valid, root_port_index, last, output ready);
endinterface

interface stp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/stp_front.sv
// Front end: accepts input words, drops ones that do nothing, and queues the rest.
`default_nettype none
module stp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	stp_in_if.sink                 rx,
	input  wire logic [3:0]        act_n,
	input  wire logic              pop,
	output stp_pkg::stp_q_t        head
);
	import stp_pkg::*;

	stp_cmd_t   q_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;
	logic       do_pop;
	stp_cmd_t   cmd;

	always_comb begin
		cmd.mode      = rx.mode;
		cmd.rx_port   = rx.rx_port;
		cmd.root_id   = rx.bpdu_root_id;
		cmd.cost      = rx.bpdu_cost;
		cmd.sender_id = rx.bpdu_switch_id;
		cmd.port_id   = rx.bpdu_port_id;
		unique case (rx.mode) inside
			MODE_START, MODE_HELLO: keep = 1'b1;
			MODE_CONFIG: keep = ({1'b0, rx.rx_port} < act_n);
			default: keep = 1'b0;
		endcase
	end

	assign rx.ready = (cnt_q != 2'd2);
	assign push = rx.valid && rx.ready && keep;
	assign do_pop = pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			if (push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= cmd;
	end
endmodule
`default_nettype wire

FILE: rtl/stp_back.sv
// Back end: sequencer that walks the port table and emits result words.
`default_nettype none
module stp_back #(
	parameter int NP = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  stp_pkg::stp_q_t   head,
	output logic              pop,
	input  wire logic [63:0]  bridge_id,
	input  wire logic [7:0]   port_priority,
	input  wire logic [15:0]  link_cost,
	input  wire logic [3:0]   act_n,
	stp_out_if.source         tx
);
	import stp_pkg::*;

	localparam int IW = $clog2(NP);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMP  = 3'd1;
	localparam logic [2:0] ST_SEL  = 3'd2;
	localparam logic [2:0] ST_SET  = 3'd3;
	localparam logic [2:0] ST_RDS  = 3'd4;
	localparam logic [2:0] ST_REF  = 3'd5;
	localparam logic [2:0] ST_MSK  = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	logic [2:0]    state_q;
	logic [63:0]   p_root_q [NP];
	logic [31:0]   p_cost_q [NP];
	logic [63:0]   p_sw_q   [NP];
	logic [15:0]   p_id_q   [NP];
	logic [63:0]   broot_q;
	logic [31:0]   bcost_q;
	logic          rpv_q;
	logic [IW-1:0] rpi_q;
	logic          hello_q;
	logic [3:0]    i_q;
	logic [NP-1:0] dmask_q;
	stp_cmd_t      cmd_q;
	logic          bv_q;
	logic [175:0]  best_q;
	logic [IW-1:0] besti_q;

	logic [IW-1:0] rd_idx;
	logic [3:0]    rd_num;
	logic [175:0]  vec;
	logic          desig;
	logic          walk_end;
	logic          out_ok;
	logic          fire;
	logic          last;
	logic          is_root;

	always_comb begin
		rd_idx = (state_q == ST_CMP) ? cmd_q.rx_port[IW-1:0] : i_q[IW-1:0];
		rd_num = 4'(rd_idx);
		vec = {p_root_q[rd_idx], p_cost_q[rd_idx], p_sw_q[rd_idx], p_id_q[rd_idx]};
		desig = (p_sw_q[rd_idx] == bridge_id) &&
			(p_id_q[rd_idx] == own_ident(port_priority, rd_num));
		walk_end = (i_q == act_n);
		out_ok = !tx.valid || tx.ready;
		fire = (state_q == ST_EMIT) && !walk_end && dmask_q[rd_idx] && out_ok;
		is_root = (broot_q == bridge_id);
		last = 1'b1;
		for (int j = 0; j < NP; j++) begin
			if ((4'(j) > i_q) && dmask_q[j]) last = 1'b0;
		end
	end

	assign pop = (state_q == ST_IDLE) && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			broot_q <= '0;
			bcost_q <= '0;
			rpv_q <= 1'b0;
			rpi_q <= '0;
			hello_q <= 1'b1;
			i_q <= '0;
			dmask_q <= '0;
			bv_q <= 1'b0;
			tx.valid <= 1'b0;
			for (int k = 0; k < NP; k++) begin
				p_root_q[k] <= '0;
				p_cost_q[k] <= '0;
				p_sw_q[k] <= '0;
				p_id_q[k] <= own_ident(8'd128, 4'(k));
			end
		end else begin
			if (fire) tx.valid <= 1'b1;
			else if (tx.ready) tx.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						i_q <= '0;
						dmask_q <= '0;
						unique case (head.cmd.mode)
							MODE_START: begin
								broot_q <= bridge_id;
								bcost_q <= '0;
								rpv_q <= 1'b0;
								rpi_q <= '0;
								hello_q <= 1'b1;
								for (int k = 0; k < NP; k++) begin
									p_root_q[k] <= bridge_id;
									p_cost_q[k] <= '0;
									p_sw_q[k] <= bridge_id;
									p_id_q[k] <= own_ident(port_priority, 4'(k));
								end
							end
							MODE_CONFIG: state_q <= ST_CMP;
							MODE_HELLO: if (hello_q) state_q <= ST_MSK;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CMP: begin
					if (vec > {cmd_q.root_id, cmd_q.cost, cmd_q.sender_id, cmd_q.port_id}) begin
						p_root_q[rd_idx] <= cmd_q.root_id;
						p_cost_q[rd_idx] <= cmd_q.cost;
						p_sw_q[rd_idx] <= cmd_q.sender_id;
						p_id_q[rd_idx] <= cmd_q.port_id;
						bv_q <= 1'b0;
						state_q <= ST_SEL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEL: begin
					if (walk_end) begin
						state_q <= ST_SET;
					end else begin
						if (!desig && (!bv_q || best_q > vec)) begin
							bv_q <= 1'b1;
							best_q <= vec;
							besti_q <= rd_idx;
						end
						i_q <= i_q + 4'd1;
					end
				end
				ST_SET: begin
					rpv_q <= bv_q;
					if (bv_q) begin
						rpi_q <= besti_q;
						broot_q <= best_q[175:112];
						bcost_q <= best_q[111:80] + {16'd0, link_cost};
					end else begin
						rpi_q <= '0;
						broot_q <= bridge_id;
						bcost_q <= '0;
					end
					i_q <= '0;
					state_q <= ST_RDS;
				end
				ST_RDS: begin
					if (walk_end) begin
						i_q <= '0;
						state_q <= ST_REF;
					end else begin
						if (!desig && (vec > {broot_q, bcost_q, bridge_id, IDENT_CAP})) begin
							p_sw_q[rd_idx] <= bridge_id;
							p_id_q[rd_idx] <= own_ident(port_priority, rd_num);
						end
						i_q <= i_q + 4'd1;
					end
				end
				ST_REF: begin
					if (walk_end) begin
						i_q <= '0;
						if (!is_root) begin
							hello_q <= 1'b0;
							state_q <= rpv_q ? ST_EMIT : ST_IDLE;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						if (desig) begin
							p_cost_q[rd_idx] <= bcost_q;
							p_root_q[rd_idx] <= broot_q;
							dmask_q[rd_idx] <= 1'b1;
						end
						i_q <= i_q + 4'd1;
					end
				end
				ST_MSK: begin
					if (walk_end) begin
						i_q <= '0;
						state_q <= (is_root || rpv_q) ? ST_EMIT : ST_IDLE;
					end else begin
						dmask_q[rd_idx] <= desig;
						i_q <= i_q + 4'd1;
					end
				end
				ST_EMIT: begin
					if (walk_end) begin
						state_q <= ST_IDLE;
					end else if (!dmask_q[rd_idx] || out_ok) begin
						i_q <= i_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head.cmd;
		if (fire) begin
			tx.tx_port <= i_q[2:0];
			tx.tx_root_id <= broot_q;
			tx.tx_cost <= bcost_q;
			tx.tx_port_id <= own_ident(port_priority, i_q);
			tx.is_root <= is_root;
			tx.root_port_valid <= rpv_q;
			tx.root_port_index <= rpv_q ? 3'(rpi_q) : 3'd0;
			tx.last <= last;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/spanning_tree_bpdu_engine_top.sv
// Top level of the spanning tree configuration BPDU engine.
// Use: write the four registers on cfg (index 0 bridge id, 1 port priority,
// 2 port count, 3 link cost) while the engine is idle; cfg is always ready.
// Send words on rx: mode 0 re-initializes every port as designated, mode 1
// delivers a received configuration BPDU for port rx_port, mode 2 is a hello
// tick. Result words leave on tx, one per BPDU to send, with last marking the
// final word that one input produced; many inputs produce no word at all.
// A front end classifies input words into a two-entry queue, and a back-end
// sequencer executes them one at a time by walking the port table, one port
// per cycle unless emission waits on a stalled receiver; a word is registered
// into the queue and taken once it heads it and the sequencer is idle. A BPDU
// that improves a port is taken, compared, walks root selection, sets the root,
// walks re-designation and refresh, then emission; a hello tick walks the port
// mask, then emission; a start ends at its take, a worse BPDU at the compare.
// Reset loads the register defaults and the port table as after a start
// with bridge id zero. When the receiver stalls, the result word is held in
// the output register and the sequencer waits, while the front end keeps
// accepting words until its queue is full.
`default_nettype none
module spanning_tree_bpdu_engine_top #(
	parameter int MAX_PORTS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	stp_in_if.sink    rx,
	stp_out_if.source tx,
	stp_cfg_if.sink   cfg
);
	import stp_pkg::*;

	// Only the first eight ports can ever be addressed.
	localparam int NP = (MAX_PORTS < HW_PORT_LIMIT) ? MAX_PORTS : HW_PORT_LIMIT;

	logic [63:0] bridge_id_q;
	logic [7:0]  port_priority_q;
	logic [3:0]  port_count_q;
	logic [15:0] link_cost_q;
	logic [3:0]  act_n;
	stp_q_t      head;
	logic        pop;

	assign cfg.ready = 1'b1;

	// Effective port count, bounded by the table depth.
	assign act_n = (port_count_q > 4'(NP)) ? 4'(NP) : port_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bridge_id_q <= '0;
			port_priority_q <= 8'd128;
			port_count_q <= 4'd4;
			link_cost_q <= 16'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BRIDGE_ID: bridge_id_q <= cfg.data;
				REG_PORT_PRIO: port_priority_q <= cfg.data[7:0];
				REG_PORT_COUNT: port_count_q <= cfg.data[3:0];
				REG_LINK_COST: link_cost_q <= cfg.data[15:0];
				default: begin
				end
			endcase
		end
	end

	stp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.act_n  (act_n),
		.pop    (pop),
		.head   (head)
	);

	stp_back #(.NP(NP)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.bridge_id     (bridge_id_q),
		.port_priority (port_priority_q),
		.link_cost     (link_cost_q),
		.act_n         (act_n),
		.tx            (tx)
	);
endmodule
`default_nettype wire

FILE: sim/spanning_tree_bpdu_engine_top_tb.sv
// Self-checking testbench of the spanning tree BPDU engine with a behavioral predictor.
`default_nettype none
module spanning_tree_bpdu_engine_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stp_pkg::*;

	localparam int NPORTS = 8;
	localparam logic [1:0] MODE_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 600;

	// One BPDU as the block should emit it.
	typedef struct packed {
		logic [2:0]  tx_port;
		logic [63:0] tx_root_id;
		logic [31:0] tx_cost;
		logic [15:0] tx_port_id;
		logic        is_root;
		logic        root_port_valid;
		logic [2:0]  root_port_index;
		logic        last;
	} bpdu_word_t;

	logic clk;
	logic arst_n;

	stp_in_if rx();
	stp_out_if tx();
	stp_cfg_if cfg();

	spanning_tree_bpdu_engine_top #(.MAX_PORTS(NPORTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx.sink),
		.tx(tx.source),
		.cfg(cfg.sink)
	);

	// The clock runs with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Predictor state: register copies and the port table of the bridge.
	logic [63:0] br_id;
	logic [7:0]  br_prio;
	logic [3:0]  br_count;
	logic [15:0] br_link_cost;
	logic [63:0] tab_root [NPORTS];
	logic [31:0] tab_cost [NPORTS];
	logic [63:0] tab_switch [NPORTS];
	logic [15:0] tab_ident [NPORTS];
	logic [63:0] cur_root;
	logic [31:0] cur_cost;
	logic        rp_ok;
	int          rp_idx;
	logic        hello_on;

	stp_cmd_t   pending_words [$];
	bpdu_word_t expected_bpdus [$];

	int mismatch_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;
	bit hold_start;
	bit hold_done;
	bit rx_took;

	function automatic logic [15:0] port_ident_of(int i);
		return {br_prio, 8'(i + 1)};
	endfunction

	function automatic int ports_in_use();
		return (br_count > NPORTS) ? NPORTS : int'(br_count);
	endfunction

	function automatic bit is_desig(int i);
		return tab_switch[i] == br_id && tab_ident[i] == port_ident_of(i);
	endfunction

	// True when vector a is strictly worse (greater) than vector b.
	function automatic bit worse(logic [63:0] ra, logic [31:0] ca, logic [63:0] sa,
			logic [15:0] pa, logic [63:0] rb, logic [31:0] cb, logic [63:0] sb,
			logic [15:0] pb);
		if (ra != rb) return ra > rb;
		if (ca != cb) return ca > cb;
		if (sa != sb) return sa > sb;
		return pa > pb;
	endfunction

	task automatic init_ports();
		cur_root = br_id;
		cur_cost = '0;
		rp_ok = 1'b0;
		rp_idx = 0;
		hello_on = 1'b1;
		for (int i = 0; i < NPORTS; i++) begin
			tab_root[i] = br_id;
			tab_cost[i] = '0;
			tab_switch[i] = br_id;
			tab_ident[i] = port_ident_of(i);
		end
	endtask

	// If root or with a root port, queue one BPDU per designated port, the last flagged.
	task automatic queue_designated();
		bpdu_word_t w;
		int k;
		bit root;
		k = 0;
		root = (cur_root == br_id);
		if (!root && !rp_ok) return;
		for (int i = 0; i < ports_in_use(); i++) begin
			if (!is_desig(i)) continue;
			w.tx_port = 3'(i);
			w.tx_root_id = cur_root;
			w.tx_cost = cur_cost;
			w.tx_port_id = port_ident_of(i);
			w.is_root = root;
			w.root_port_valid = rp_ok;
			w.root_port_index = rp_ok ? 3'(rp_idx) : 3'd0;
			w.last = 1'b0;
			expected_bpdus.push_back(w);
			k++;
		end
		if (k > 0) expected_bpdus[$].last = 1'b1;
	endtask

	task automatic predict_bpdus(stp_cmd_t c);
		int p;
		p = int'(c.rx_port);
		case (c.mode)
			MODE_START: begin
				init_ports();
			end
			MODE_HELLO: begin
				if (hello_on) queue_designated();
			end
			MODE_CONFIG: begin
				if (p >= ports_in_use()) return;
				if (!worse(tab_root[p], tab_cost[p], tab_switch[p], tab_ident[p],
						c.root_id, c.cost, c.sender_id, c.port_id)) return;
				tab_root[p] = c.root_id;
				tab_cost[p] = c.cost;
				tab_switch[p] = c.sender_id;
				tab_ident[p] = c.port_id;
				// Root port selection: best non-designated port, lowest index on ties.
				rp_ok = 1'b0;
				rp_idx = 0;
				for (int i = 0; i < ports_in_use(); i++) begin
					if (is_desig(i)) continue;
					if (!rp_ok || worse(tab_root[rp_idx], tab_cost[rp_idx],
							tab_switch[rp_idx], tab_ident[rp_idx], tab_root[i],
							tab_cost[i], tab_switch[i], tab_ident[i])) begin
						rp_ok = 1'b1;
						rp_idx = i;
					end
				end
				if (!rp_ok) begin
					cur_root = br_id;
					cur_cost = '0;
				end else begin
					cur_root = tab_root[rp_idx];
					cur_cost = tab_cost[rp_idx] + 32'(br_link_cost);
				end
				// Ports worse than what this bridge would offer become designated.
				for (int i = 0; i < ports_in_use(); i++) begin
					if (is_desig(i)) continue;
					if (worse(tab_root[i], tab_cost[i], tab_switch[i], tab_ident[i],
							cur_root, cur_cost, br_id, IDENT_CAP)) begin
						tab_switch[i] = br_id;
						tab_ident[i] = port_ident_of(i);
					end
				end
				for (int i = 0; i < ports_in_use(); i++) begin
					if (is_desig(i)) begin
						tab_cost[i] = cur_cost;
						tab_root[i] = cur_root;
					end
				end
				if (cur_root != br_id) begin
					hello_on = 1'b0;
					queue_designated();
				end
			end
			default: begin
			end
		endcase
	endtask

	// Driver: offers the oldest pending word, with random idle cycles.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx.valid <= 1'b0;
			rx.mode <= MODE_UNKNOWN;
			rx.rx_port <= '0;
			rx.bpdu_root_id <= '0;
			rx.bpdu_cost <= '0;
			rx.bpdu_switch_id <= '0;
			rx.bpdu_port_id <= '0;
		end else if (!rx.valid || rx_took) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				rx.valid <= 1'b1;
				rx.mode <= pending_words[0].mode;
				rx.rx_port <= pending_words[0].rx_port;
				rx.bpdu_root_id <= pending_words[0].root_id;
				rx.bpdu_cost <= pending_words[0].cost;
				rx.bpdu_switch_id <= pending_words[0].sender_id;
				rx.bpdu_port_id <= pending_words[0].port_id;
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// Acceptance at the rising edge feeds the predictor and retires the word.
	always @(posedge clk) begin
		rx_took = arst_n && rx.valid && rx.ready;
		if (rx_took) begin
			predict_bpdus(pending_words.pop_front());
		end
	end

	// Receiver ready, with random stalls and the long hold-off.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) tx.ready <= 1'b0;
		else tx.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted in clock cycles once requested.
	initial begin
		hold_off = 1'b0;
		hold_done = 1'b0;
		wait (hold_start);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
		hold_done = 1'b1;
	end

	// Monitor: compares each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		bpdu_word_t got;
		bpdu_word_t want;
		if (arst_n && tx.valid && tx.ready) begin
			got = '{tx.tx_port, tx.tx_root_id, tx.tx_cost, tx.tx_port_id, tx.is_root,
				tx.root_port_valid, tx.root_port_index, tx.last};
			if (expected_bpdus.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result word %p", got);
			end else begin
				want = expected_bpdus.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("spanning_tree_bpdu_engine_top_tb failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_BRIDGE_ID: br_id = value;
			REG_PORT_PRIO: br_prio = value[7:0];
			REG_PORT_COUNT: br_count = value[3:0];
			default: br_link_cost = value[15:0];
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic push_word(logic [1:0] m, logic [2:0] p, logic [63:0] r, logic [31:0] c,
			logic [63:0] s, logic [15:0] id);
		stp_cmd_t w;
		w.mode = m;
		w.rx_port = p;
		w.root_id = r;
		w.cost = c;
		w.sender_id = s;
		w.port_id = id;
		pending_words.push_back(w);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Wait for the block to drain, then allow for trailing no-result items.
	task automatic drain();
		while (pending_words.size() > 0 || expected_bpdus.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// One random item; mostly BPDUs whose vector is near the bridge id so that
	// they improve ports, plus hellos, starts and noise.
	task automatic push_random();
		int sel;
		logic [63:0] base;
		sel = $urandom_range(99);
		base = br_id - 64'($urandom_range(3));
		if (sel < 6) push_word(MODE_START, 3'($urandom), rand64(), $urandom(), rand64(),
			16'($urandom));
		else if (sel < 22) push_word(MODE_HELLO, 3'($urandom), rand64(), $urandom(),
			rand64(), 16'($urandom));
		else if (sel < 25) push_word(MODE_UNKNOWN, 3'($urandom), rand64(), $urandom(),
			rand64(), 16'($urandom));
		else if (sel < 35) push_word(MODE_CONFIG, 3'($urandom), rand64(), $urandom(),
			rand64(), 16'($urandom));
		else push_word(MODE_CONFIG, 3'($urandom_range(ports_in_use() > 0 ?
			ports_in_use() - 1 : 0)), base, $urandom_range(3) == 0 ? $urandom() :
			32'($urandom_range(6)), br_id + 64'($urandom_range(2)) - 64'd1,
			16'($urandom));
	endtask

	task automatic random_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) push_random();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_BRIDGE_ID;
		cfg.data = '0;
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		br_id = '0;
		br_prio = 8'd128;
		br_count = 4'd4;
		br_link_cost = 16'd1;
		init_ports();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under reset defaults: a hello, unknown mode, unused
		// port and a BPDU that is not better.
		push_word(MODE_HELLO, 3'd0, '0, '0, '0, '0);
		push_word(MODE_UNKNOWN, 3'd7, '1, '1, '1, '1);
		push_word(MODE_CONFIG, 3'd7, '0, '0, '0, '0);
		push_word(MODE_CONFIG, 3'd0, '1, '1, '1, '1);
		drain();
		write_reg(REG_BRIDGE_ID, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_PORT_PRIO, 8'hFF);
		write_reg(REG_PORT_COUNT, 4'd8);
		write_reg(REG_LINK_COST, 16'hFFFF);
		push_word(MODE_START, 3'd0, '0, '0, '0, '0);
		push_word(MODE_CONFIG, 3'd3, 64'd5, 32'hFFFF_FFFF, 64'd9, 16'hFFFF);
		push_word(MODE_CONFIG, 3'd5, 64'd5, 32'hFFFF_FFFF, 64'd9, 16'hFFFF);
		push_word(MODE_CONFIG, 3'd7, '0, '0, '0, '0);
		push_word(MODE_HELLO, 3'd0, '0, '0, '0, '0);
		push_word(MODE_START, 3'd0, '0, '0, '0, '0);
		push_word(MODE_HELLO, 3'd0, '0, '0, '0, '0);
		// Better vector from a bridge whose root is ourselves: re-designation case.
		push_word(MODE_CONFIG, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 64'd1, 16'd0);
		push_word(MODE_HELLO, 3'd0, '0, '0, '0, '0);
		drain();
		write_reg(REG_PORT_COUNT, 4'd0);
		push_word(MODE_START, 3'd0, '0, '0, '0, '0);
		push_word(MODE_CONFIG, 3'd0, '0, '0, '0, '0);
		push_word(MODE_HELLO, 3'd0, '0, '0, '0, '0);
		drain();
		write_reg(REG_PORT_COUNT, 4'd15);
		write_reg(REG_PORT_PRIO, 8'h00);
		write_reg(REG_LINK_COST, 16'h0000);
		push_word(MODE_START, 3'd0, '0, '0, '0, '0);
		push_word(MODE_CONFIG, 3'd7, '0, 32'd3, '0, '0);
		push_word(MODE_HELLO, 3'd0, '0, '0, '0, '0);
		drain();

		// Random phases with different settings and idling patterns.
		write_reg(REG_BRIDGE_ID, 64'h8000_0000_0000_0040);
		write_reg(REG_PORT_PRIO, 8'd128);
		write_reg(REG_PORT_COUNT, 4'd4);
		write_reg(REG_LINK_COST, 16'd4);
		random_phase(100, 0, 0);
		write_reg(REG_BRIDGE_ID, rand64());
		write_reg(REG_PORT_COUNT, 4'd8);
		write_reg(REG_LINK_COST, 16'($urandom));
		random_phase(80, 86, 0);
		write_reg(REG_PORT_PRIO, 8'($urandom));
		write_reg(REG_PORT_COUNT, 4'd2);
		random_phase(80, 0, 86);
		write_reg(REG_BRIDGE_ID, 64'hFFFF_FFFF_FFFF_FFF0);
		write_reg(REG_PORT_COUNT, 4'd1);
		write_reg(REG_LINK_COST, 16'hFFFF);
		random_phase(60, 30, 30);

		// Pressure: the receiver holds off while the sender keeps offering words.
		write_reg(REG_PORT_COUNT, 4'd8);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_start = 1'b1;
		for (int i = 0; i < 20; i++) push_random();
		push_word(MODE_START, 3'd0, '0, '0, '0, '0);
		push_word(MODE_CONFIG, 3'd2, 64'd0, 32'd0, 64'd0, 16'd0);
		for (int i = 0; i < 10; i++) push_word(MODE_HELLO, 3'd0, '0, '0, '0, '0);
		wait (hold_done);
		drain();

		if (mismatch_count == 0 && expected_bpdus.size() == 0) begin
			$display("spanning_tree_bpdu_engine_top_tb passed");
		end else begin
			$display("spanning_tree_bpdu_engine_top_tb failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/stp_pkg.sv
rtl/stp_ifs.sv
rtl/stp_front.sv
rtl/stp_back.sv
rtl/spanning_tree_bpdu_engine_top.sv
sim/spanning_tree_bpdu_engine_top_tb.sv
